// File: rtl/core/per_slot_presence_debounce_assert.svh
// assertion macros for the per-slot presence debounce block
`ifndef PER_SLOT_PRESENCE_DEBOUNCE_ASSERT_SVH
`define PER_SLOT_PRESENCE_DEBOUNCE_ASSERT_SVH

// same-cycle implication
`define PSPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pspd_pkg.sv
// shared constants, types and command/status structs for the presence debounce block
package pspd_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W    = 6;
   localparam int TIME_W    = 32;
   localparam int DEB_W     = 31;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CMP_W     = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(600);
   localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(NUM_SLOTS - 1);
   localparam logic [CMP_W-1:0] SLOT_LIMIT     = CMP_W'(NUM_SLOTS);

   localparam logic OP_NOTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NOTE_EVAL,
      ST_SCAN_READ,
      ST_SCAN_EVAL,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic              committed;
      logic              pending;
      logic              pend_pres;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic rd_note;
      logic rd_scan;
      logic wr_note;
      logic wr_scan;
      logic idx_clear;
      logic idx_incr;
      logic held_load;
      logic push_held;
      logic push_last;
   } cmd_type;

   typedef struct packed {
      logic op_tick;
      logic slot_ok;
      logic settle;
      logic report;
      logic held_valid;
      logic out_free;
      logic idx_last;
   } status_type;

endpackage

// File: rtl/core/pspd_ctrl.sv
// controller state machine: sequences note updates and the tick scan
module pspd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pspd_pkg::status_type  status,
   output pspd_pkg::cmd_type     cmd
);

   pspd_pkg::state_type state_ff;
   pspd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pspd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         pspd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.op_tick) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = pspd_pkg::ST_SCAN_READ;
               end else if (status.slot_ok) begin
                  cmd.rd_note = 1'b1;
                  state_in    = pspd_pkg::ST_NOTE_EVAL;
               end
            end
         end
         pspd_pkg::ST_NOTE_EVAL: begin
            cmd.wr_note = 1'b1;
            state_in    = pspd_pkg::ST_IDLE;
         end
         pspd_pkg::ST_SCAN_READ: begin
            cmd.rd_scan = 1'b1;
            state_in    = pspd_pkg::ST_SCAN_EVAL;
         end
         pspd_pkg::ST_SCAN_EVAL: begin
            if (!(status.report && status.held_valid && !status.out_free)) begin
               cmd.wr_scan = status.settle;
               if (status.report) begin
                  cmd.held_load = 1'b1;
                  cmd.push_held = status.held_valid;
               end
               if (status.idx_last) begin
                  state_in = pspd_pkg::ST_SCAN_END;
               end else begin
                  cmd.idx_incr = 1'b1;
                  state_in     = pspd_pkg::ST_SCAN_READ;
               end
            end
         end
         pspd_pkg::ST_SCAN_END: begin
            if (!status.held_valid) begin
               state_in = pspd_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.push_last = 1'b1;
               state_in      = pspd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pspd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/pspd_datapath.sv
// datapath: slot table, known bits, settle compare, held report and output register
module pspd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pspd_pkg::DEB_W-1:0]   csr_wr_data,
   input  logic                         req_operation,
   input  logic [pspd_pkg::SLOT_W-1:0]  req_slot,
   input  logic                         req_present,
   input  logic [pspd_pkg::TIME_W-1:0]  req_now_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pspd_pkg::SLOT_W-1:0]  rsp_commit_slot,
   output logic                         rsp_commit_present,
   output logic                         rsp_last_commit,
   input  pspd_pkg::cmd_type            cmd,
   output pspd_pkg::status_type         status
);

   logic [pspd_pkg::DEB_W-1:0]  deb_ff, deb_in;
   logic [pspd_pkg::IDX_W-1:0]  slot_ff, slot_in;
   logic                        present_ff, present_in;
   logic [pspd_pkg::TIME_W-1:0] now_ff, now_in;
   logic [pspd_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [pspd_pkg::NUM_SLOTS-1:0] known_ff, known_in;

   pspd_pkg::entry_type entry_mem_ff [pspd_pkg::NUM_SLOTS];
   pspd_pkg::entry_type rd_ff;
   pspd_pkg::entry_type note_entry;
   pspd_pkg::entry_type wr_entry;
   logic [pspd_pkg::IDX_W-1:0] rd_addr;
   logic [pspd_pkg::IDX_W-1:0] wr_addr;
   logic                       wr_en;
   logic                       rd_en;

   logic                        held_valid_ff, held_valid_in;
   logic [pspd_pkg::SLOT_W-1:0] held_slot_ff, held_slot_in;
   logic                        held_present_ff, held_present_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pspd_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                        rsp_present_ff, rsp_present_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [pspd_pkg::TIME_W-1:0] diff;
   logic                        known_note;
   logic                        known_scan;
   logic                        push;

   // capture and configuration
   always_comb begin
      deb_in     = csr_wr_en ? csr_wr_data : deb_ff;
      slot_in    = cmd.capture ? pspd_pkg::IDX_W'(req_slot) : slot_ff;
      present_in = cmd.capture ? req_present : present_ff;
      now_in     = cmd.capture ? req_now_ms : now_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_incr) begin
         idx_in = idx_ff + pspd_pkg::IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= pspd_pkg::DEBOUNCE_RESET;
      end else begin
         deb_ff <= deb_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      present_ff <= present_in;
      now_ff     <= now_in;
      idx_ff     <= idx_in;
   end

   // slot table
   assign rd_en   = cmd.rd_note | cmd.rd_scan;
   assign rd_addr = cmd.rd_note ? pspd_pkg::IDX_W'(req_slot) : idx_ff;
   assign wr_en   = cmd.wr_note | cmd.wr_scan;
   assign wr_addr = cmd.wr_note ? slot_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
   end

   assign known_note = known_ff[slot_ff];
   assign known_scan = known_ff[idx_ff];

   always_comb begin
      note_entry = rd_ff;
      if (!known_note) begin
         note_entry.committed = present_ff;
         note_entry.pending   = 1'b0;
         note_entry.pend_pres = present_ff;
         note_entry.stamp     = now_ff;
      end else if (present_ff == rd_ff.committed) begin
         note_entry.pending = 1'b0;
      end else if (!rd_ff.pending || (rd_ff.pend_pres != present_ff)) begin
         note_entry.pending   = 1'b1;
         note_entry.pend_pres = present_ff;
         note_entry.stamp     = now_ff;
      end
   end

   always_comb begin
      wr_entry = rd_ff;
      if (cmd.wr_note) begin
         wr_entry = note_entry;
      end else begin
         wr_entry.committed = rd_ff.pend_pres;
         wr_entry.pending   = 1'b0;
      end
   end

   always_comb begin
      known_in = known_ff;
      if (cmd.wr_note) begin
         known_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else begin
         known_ff <= known_in;
      end
   end

   // settle compare, wrapping signed age
   assign diff = now_ff - rd_ff.stamp;

   always_comb begin
      status.op_tick    = (req_operation == pspd_pkg::OP_TICK);
      status.slot_ok    = (pspd_pkg::CMP_W'(req_slot) < pspd_pkg::SLOT_LIMIT);
      status.settle     = known_scan && rd_ff.pending && !diff[pspd_pkg::TIME_W-1]
                          && (diff[pspd_pkg::DEB_W-1:0] >= deb_ff);
      status.report     = status.settle && (rd_ff.pend_pres != rd_ff.committed);
      status.held_valid = held_valid_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.idx_last   = (idx_ff == pspd_pkg::IDX_LAST);
   end

   // held report waits for the next one to know whether it is the last
   always_comb begin
      held_valid_in   = held_valid_ff;
      held_slot_in    = held_slot_ff;
      held_present_in = held_present_ff;
      if (cmd.held_load) begin
         held_valid_in   = 1'b1;
         held_slot_in    = pspd_pkg::SLOT_W'(idx_ff);
         held_present_in = rd_ff.pend_pres;
      end else if (cmd.push_last) begin
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_slot_ff    <= held_slot_in;
      held_present_ff <= held_present_in;
   end

   // output word register
   assign push = cmd.push_held | cmd.push_last;

   always_comb begin
      rsp_slot_in    = rsp_slot_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_slot_in    = held_slot_ff;
         rsp_present_in = held_present_ff;
         rsp_last_in    = cmd.push_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff    <= rsp_slot_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_commit_slot    = rsp_slot_ff;
   assign rsp_commit_present = rsp_present_ff;
   assign rsp_last_commit    = rsp_last_ff;

endmodule

// File: rtl/core/per_slot_presence_debounce.sv
// top level of the per-slot presence debounce block
// usage:
//   req_ channel carries one word per event: a presence note for one slot or a
//   settle tick; a word is taken when req_valid is high and req_stall is low.
//   a note reads its slot entry when taken and rewrites it in ST_NOTE_EVAL;
//   the next word is taken in the cycle after the rewrite. a note for a slot
//   at or beyond NUM_SLOTS is dropped; with 6-bit slots none can be.
//   a tick walks the table in ascending slot order (read in ST_SCAN_READ,
//   settled write-back in ST_SCAN_EVAL); no word is taken until it ends.
//   rsp_ channel delivers one word per committed change: slot, new presence
//   and a flag on the final word of the tick; a tick with nothing settled
//   sends nothing. each commit is held until the next one or the walk's end
//   so the final flag is known; a push to a stalled full output halts the walk.
//   csr_wr_en with csr_wr_data sets the hold time in ms, written while idle.
//   reset (synchronous) clears all slot knowledge and sets the hold to 600 ms;
//   the table itself needs no clearing pass.
module per_slot_presence_debounce (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [pspd_pkg::DEB_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [pspd_pkg::SLOT_W-1:0]  req_slot,
   input  logic                         req_present,
   input  logic [pspd_pkg::TIME_W-1:0]  req_now_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pspd_pkg::SLOT_W-1:0]  rsp_commit_slot,
   output logic                         rsp_commit_present,
   output logic                         rsp_last_commit
);

`include "per_slot_presence_debounce_assert.svh"

   pspd_pkg::cmd_type    cmd;
   pspd_pkg::status_type status;

   logic push_any;
   logic out_busy;
   logic req_take;
   logic tick_take;
   logic table_wr;

   pspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pspd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_present        (req_present),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_commit_slot    (rsp_commit_slot),
      .rsp_commit_present (rsp_commit_present),
      .rsp_last_commit    (rsp_last_commit),
      .cmd                (cmd),
      .status             (status)
   );

   assign push_any  = cmd.push_held | cmd.push_last;
   assign out_busy  = rsp_valid & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign tick_take = req_take & (req_operation == pspd_pkg::OP_TICK);
   assign table_wr  = cmd.wr_note | cmd.wr_scan;

   `PSPD_ASSERT_NOW(a_push_needs_room, push_any, !out_busy, "word pushed over a stalled result")
   `PSPD_ASSERT_NOW(a_no_write_on_accept, req_take, !table_wr, "table write on accept")
   `PSPD_ASSERT_NEXT(a_tick_starts_scan, tick_take, cmd.rd_scan && req_stall, "no walk after tick")

endmodule

// File: tb/tb_per_slot_presence_debounce.sv
// testbench for the per-slot presence debounce block: table walk, random bursts, settle predictor
module tb_per_slot_presence_debounce;

   localparam int SETTLE_CYCLES = 2 * pspd_pkg::NUM_SLOTS + 200;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_WORDS   = 58;

   typedef struct packed {
      logic [pspd_pkg::SLOT_W-1:0] slot;
      logic                        present;
      logic                        last;
   } commit_type;

   typedef struct packed {
      logic                        op;
      logic [pspd_pkg::SLOT_W-1:0] slot;
      logic                        present;
      logic [pspd_pkg::TIME_W-1:0] now;
      logic                        typed;
      logic                        has_commit;
      logic [pspd_pkg::SLOT_W-1:0] c_slot;
      logic                        c_present;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [pspd_pkg::DEB_W-1:0]    csr_wr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_operation = pspd_pkg::OP_NOTE;
   logic [pspd_pkg::SLOT_W-1:0]   req_slot = '0;
   logic                          req_present = 1'b0;
   logic [pspd_pkg::TIME_W-1:0]   req_now_ms = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [pspd_pkg::SLOT_W-1:0]   rsp_commit_slot;
   logic                          rsp_commit_present;
   logic                          rsp_last_commit;

   logic                          slot_known     [pspd_pkg::NUM_SLOTS] = '{default: 1'b0};
   logic                          slot_committed [pspd_pkg::NUM_SLOTS] = '{default: 1'b0};
   logic                          slot_pending   [pspd_pkg::NUM_SLOTS] = '{default: 1'b0};
   logic                          slot_pend_pres [pspd_pkg::NUM_SLOTS] = '{default: 1'b0};
   logic [pspd_pkg::TIME_W-1:0]   slot_stamp     [pspd_pkg::NUM_SLOTS] = '{default: '0};
   logic [pspd_pkg::DEB_W-1:0]    hold_ms = pspd_pkg::DEBOUNCE_RESET;

   commit_type                    settled[$];
   commit_type                    commit_q[$];
   logic [pspd_pkg::TIME_W-1:0]   clock_ms;
   int                            snd_idle_pct = 20;
   int                            rcv_idle_pct = 51;
   int                            faults = 0;
   int                            cycle_count = 0;

   stim_row_type plan [0:24] = '{
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd0,  1'b1, 32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd63, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd0,  1'b0, 32'h0000_0064, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd63, 1'b1, 32'h0000_0064, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_02BB, 1'b1, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd0,  1'b1, 32'h0000_028A, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_02BC, 1'b1, 1'b1, 6'd63, 1'b1},
      '{pspd_pkg::OP_NOTE, 6'd21, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd21, 1'b0, 32'hFFFF_FF00, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_0200, 1'b1, 1'b1, 6'd21, 1'b0},
      '{pspd_pkg::OP_NOTE, 6'd42, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd42, 1'b1, 32'h8000_0000, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_0000, 1'b1, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd42, 1'b1, 32'h0000_0005, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h8000_0258, 1'b1, 1'b1, 6'd42, 1'b1},
      '{pspd_pkg::OP_NOTE, 6'd1,  1'b0, 32'h0000_000A, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd1,  1'b1, 32'h0000_000A, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd2,  1'b1, 32'h0000_000A, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd2,  1'b0, 32'h0000_0014, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_03E8, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_03E8, 1'b1, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_NOTE, 6'd63, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0,  1'b0},
      '{pspd_pkg::OP_TICK, 6'd0,  1'b0, 32'h0000_0257, 1'b1, 1'b1, 6'd63, 1'b0}
   };

   per_slot_presence_debounce DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_present        (req_present),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_commit_slot    (rsp_commit_slot),
      .rsp_commit_present (rsp_commit_present),
      .rsp_last_commit    (rsp_last_commit)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void predict_settled_commits(
      input logic                        op,
      input logic [pspd_pkg::SLOT_W-1:0] slot,
      input logic                        pres,
      input logic [pspd_pkg::TIME_W-1:0] now
   );
      logic [pspd_pkg::TIME_W-1:0] gap;
      settled.delete();
      if (op == pspd_pkg::OP_NOTE) begin
         if (!slot_known[slot]) begin
            slot_known[slot]     = 1'b1;
            slot_committed[slot] = pres;
         end else if (pres == slot_committed[slot]) begin
            slot_pending[slot] = 1'b0;
         end else if (!slot_pending[slot] || slot_pend_pres[slot] != pres) begin
            slot_pending[slot]   = 1'b1;
            slot_pend_pres[slot] = pres;
            slot_stamp[slot]     = now;
         end
      end else begin
         for (int s = 0; s < pspd_pkg::NUM_SLOTS; s++) begin
            gap = now - slot_stamp[s];
            if (slot_pending[s] && !gap[pspd_pkg::TIME_W-1] && gap >= {1'b0, hold_ms}) begin
               slot_pending[s] = 1'b0;
               if (slot_pend_pres[s] != slot_committed[s]) begin
                  slot_committed[s] = slot_pend_pres[s];
                  settled.push_back('{slot: pspd_pkg::SLOT_W'(s), present: slot_pend_pres[s],
                                      last: 1'b0});
               end
            end
         end
         if (settled.size() > 0) settled[settled.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic send_word(input logic op, input logic [pspd_pkg::SLOT_W-1:0] slot,
                            input logic pres, input logic [pspd_pkg::TIME_W-1:0] now,
                            input bit use_predicted);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= slot;
      req_present   <= pres;
      req_now_ms    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_settled_commits(op, slot, pres, now);
      if (use_predicted) begin
         foreach (settled[j]) commit_q.push_back(settled[j]);
      end
   endtask

   task automatic drain_commits(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (commit_q.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold(input logic [pspd_pkg::DEB_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      hold_ms = value;
   endtask

   task automatic run_bursts(input int count, input bit pause_midway);
      int                          sent;
      int                          burst;
      bit                          paused;
      logic [pspd_pkg::SLOT_W-1:0] slot;
      logic                        pres;
      logic [pspd_pkg::TIME_W-1:0] tick_ms;
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 2) begin
            send_word(logic'($urandom_range(0, 1)),
                      pspd_pkg::SLOT_W'($urandom_range(0, pspd_pkg::NUM_SLOTS - 1)),
                      logic'($urandom_range(0, 1)), $urandom(), 1'b1);
            sent++;
         end else begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               slot = pspd_pkg::SLOT_W'($urandom_range(0, pspd_pkg::NUM_SLOTS - 1));
               if (!slot_known[slot] || $urandom_range(0, 3) == 0)
                  pres = logic'($urandom_range(0, 1));
               else
                  pres = ~slot_committed[slot];
               clock_ms = clock_ms + $urandom_range(0, 4);
               send_word(pspd_pkg::OP_NOTE, slot, pres, clock_ms, 1'b1);
               sent++;
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: tick_ms = clock_ms + {1'b0, hold_ms} + $urandom_range(0, 3);
               6, 7:             tick_ms = clock_ms + {1'b0, hold_ms} - $urandom_range(1, 3);
               8:                tick_ms = $urandom();
               default:          tick_ms = clock_ms;
            endcase
            send_word(pspd_pkg::OP_TICK,
                      pspd_pkg::SLOT_W'($urandom_range(0, pspd_pkg::NUM_SLOTS - 1)),
                      logic'($urandom_range(0, 1)), tick_ms, 1'b1);
            clock_ms = tick_ms;
            sent++;
         end
         if (pause_midway && !paused && sent >= count / 2) begin
            drain_commits(1'b0);
            paused = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : check_commits
      commit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (commit_q.size() == 0) begin
            $error("commit word with none expected: slot %0d present %0b last %0b",
                   rsp_commit_slot, rsp_commit_present, rsp_last_commit);
            faults++;
         end else begin
            want = commit_q.pop_front();
            if (rsp_commit_slot !== want.slot) begin
               $error("commit_slot expected %0d actual %0d", want.slot, rsp_commit_slot);
               faults++;
            end
            if (rsp_commit_present !== want.present) begin
               $error("commit_present expected %0b actual %0b", want.present,
                      rsp_commit_present);
               faults++;
            end
            if (rsp_last_commit !== want.last) begin
               $error("last_commit expected %0b actual %0b", want.last, rsp_last_commit);
               faults++;
            end
         end
      end
   end

   initial begin
      clock_ms = $urandom();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         send_word(plan[i].op, plan[i].slot, plan[i].present, plan[i].now, !plan[i].typed);
         if (plan[i].typed && plan[i].has_commit)
            commit_q.push_back('{slot: plan[i].c_slot, present: plan[i].c_present, last: 1'b1});
      end

      drain_commits(1'b1);
      write_hold('0);
      run_bursts(PHASE_WORDS, 1'b0);

      drain_commits(1'b1);
      snd_idle_pct = 51;
      rcv_idle_pct = 20;
      write_hold({pspd_pkg::DEB_W{1'b1}});
      run_bursts(PHASE_WORDS, 1'b1);

      drain_commits(1'b1);
      write_hold(pspd_pkg::DEB_W'($urandom_range(1, 5000)));
      run_bursts(PHASE_WORDS, 1'b0);

      drain_commits(1'b1);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_hold(pspd_pkg::DEBOUNCE_RESET);
      run_bursts(PHASE_WORDS, 1'b0);

      drain_commits(1'b1);
      if (faults == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
